@@ hdl/min_max_feature_normalizer_macros.svh @@
// Assertion macros for the min-max feature normaliser.
// Expects clk and rst_n in the scope of use; no other dependencies.
`ifndef MIN_MAX_FEATURE_NORMALIZER_MACROS_SVH
`define MIN_MAX_FEATURE_NORMALIZER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MMFN_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MMFN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/mmfn_pkg.sv @@
// Shared types and constants of the min-max feature normaliser.
// No dependencies; used by mmfn_store, mmfn_divider and the top level.
package mmfn_pkg;

    localparam int unsigned FEATURES_DEF = 256;
    localparam int unsigned DATA_W       = 32;
    localparam int unsigned FRAC_W       = 16;
    localparam int unsigned IDX_W        = 8;
    localparam int unsigned DIV_STEPS    = 32;
    localparam int unsigned CFG_ADDR_W   = 3;
    localparam int unsigned CFG_DATA_W   = 32;

    typedef logic [2:0] kind_t;

    localparam kind_t KIND_CLEAR   = 3'd0;
    localparam kind_t KIND_COLLECT = 3'd1;
    localparam kind_t KIND_FINISH  = 3'd2;
    localparam kind_t KIND_NORM    = 3'd3;
    localparam kind_t KIND_DENORM  = 3'd4;

    // Register index, taken from byte address bit 2
    localparam logic REG_DENORM_EN = 1'b0;

    localparam logic signed [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_SETUP,
        ST_DIVIDE,
        ST_SCALE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic                     seen;
        logic signed [DATA_W-1:0] high;
        logic signed [DATA_W-1:0] low;
    } entry_t;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] rem_init;
        logic [DATA_W-1:0] dq_init;
        logic [DATA_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quotient;
    } div_rsp_t;

endpackage

@@ hdl/mmfn_store.sv @@
// Statistics store: one synchronous RAM of min/max/seen entries, registered read.
// Depends on mmfn_pkg for the entry type.
module mmfn_store #(
    parameter int unsigned DEPTH = 2 * mmfn_pkg::FEATURES_DEF,
    localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_W-1:0]    waddr,
    input  mmfn_pkg::entry_t     wdata,
    input  logic                 re,
    input  logic [ADDR_W-1:0]    raddr,
    output mmfn_pkg::entry_t     rdata
);

    mmfn_pkg::entry_t store_mem [DEPTH];
    mmfn_pkg::entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= store_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/mmfn_divider.sv @@
// Restoring divider: one quotient bit per cycle, DIV_STEPS bits per division.
// Depends on mmfn_pkg for the request and response structs.
module mmfn_divider (
    input  logic                clk,
    input  logic                rst_n,
    input  mmfn_pkg::div_req_t  req,
    output mmfn_pkg::div_rsp_t  rsp
);

    localparam int unsigned W     = mmfn_pkg::DATA_W;
    localparam int unsigned CNT_W = $clog2(mmfn_pkg::DIV_STEPS);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] count_reg;
    logic [W-1:0]     rem_reg;
    logic [W-1:0]     dq_reg;
    logic [W-1:0]     divisor_reg;

    logic [W:0]       partial;
    logic             fits;
    logic [W-1:0]     rem_next;
    logic [W-1:0]     dq_next;

    // Remainder stays below the divisor, so the trial fits back into W bits
    always_comb
    begin
        partial  = {rem_reg, dq_reg[W-1]};
        fits     = partial >= {1'b0, divisor_reg};
        rem_next = fits ? W'(partial - {1'b0, divisor_reg}) : partial[W-1:0];
        dq_next  = {dq_reg[W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= '0;
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg + 1'b1;
                if (count_reg == CNT_W'(mmfn_pkg::DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg     <= req.rem_init;
            dq_reg      <= req.dq_init;
            divisor_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dq_reg  <= dq_next;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = dq_reg;

endmodule

@@ hdl/min_max_feature_normalizer.sv @@
// Min-max feature normaliser, top level; uses mmfn_pkg, mmfn_store, mmfn_divider.
// Normalise: LOOKUP, SETUP, DIVIDE (32-step divider), FINISH; SETUP skips DIVIDE
// when the span is zero or the quotient overflows. Denormalise: LOOKUP, SETUP, SCALE,
// FINISH. Collect: LOOKUP with write-back; finish acts on accept; clear sweeps the RAM.
// Pass-through results (stats not ready, disabled, out of range) go straight to FINISH.
// Reset: asynchronous; then the RAM is swept with in_stall high. One request at a time.
`include "min_max_feature_normalizer_macros.svh"

module min_max_feature_normalizer #(
    parameter int unsigned FEATURES = mmfn_pkg::FEATURES_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [mmfn_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [mmfn_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [mmfn_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                 pready,

    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  mmfn_pkg::kind_t                      kind,
    input  logic                                 bank,
    input  logic [mmfn_pkg::IDX_W-1:0]           feature_index,
    input  logic signed [mmfn_pkg::DATA_W-1:0]   sample_value,

    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [mmfn_pkg::DATA_W-1:0]   result_value,
    output logic                                 saturated
);

    localparam int unsigned DEPTH  = 2 * FEATURES;
    localparam int unsigned ADDR_W = $clog2(DEPTH);
    localparam int unsigned W      = mmfn_pkg::DATA_W;
    localparam int unsigned FRAC_W = mmfn_pkg::FRAC_W;
    localparam int unsigned PROD_W = 2 * W;
    localparam int unsigned SUM_W  = PROD_W - FRAC_W + 1;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    mmfn_pkg::state_t      state_reg;
    mmfn_pkg::state_t      state_next;
    logic [ADDR_W-1:0]     clr_addr_reg;
    logic                  stats_ready_reg;
    logic                  denorm_en_reg;
    logic                  out_valid_reg;

    mmfn_pkg::kind_t       kind_reg;
    logic signed [W-1:0]   x_reg;
    logic [ADDR_W-1:0]     addr_reg;
    logic signed [W-1:0]   lo_reg;
    logic [W-1:0]          span_reg;
    logic                  neg_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [W-1:0]   res_reg;
    logic                  sat_reg;
    logic signed [W-1:0]   result_value_reg;
    logic                  saturated_reg;

    // ------------------------------------------------------------------
    // Request decode
    // ------------------------------------------------------------------
    logic                  in_accept;
    logic                  idx_in_range;
    logic                  look_bank;
    logic [ADDR_W-1:0]     look_addr;
    logic                  need_lookup;
    logic                  pass_result;
    logic                  out_free;
    logic                  cfg_write;

    assign in_accept    = in_valid && !in_stall;
    assign idx_in_range = 32'(feature_index) < FEATURES;
    // Denormalise always works on the output bank
    assign look_bank    = (kind == mmfn_pkg::KIND_DENORM) ? 1'b1 : bank;
    assign look_addr    = ADDR_W'(feature_index) + (look_bank ? ADDR_W'(FEATURES) : '0);
    assign need_lookup  = idx_in_range &&
                          ((kind == mmfn_pkg::KIND_COLLECT) ||
                           (kind == mmfn_pkg::KIND_NORM && stats_ready_reg) ||
                           (kind == mmfn_pkg::KIND_DENORM && stats_ready_reg && denorm_en_reg));
    assign pass_result  = ((kind == mmfn_pkg::KIND_NORM) || (kind == mmfn_pkg::KIND_DENORM))
                          && !need_lookup;
    assign out_free     = !out_valid_reg || !out_stall;
    assign cfg_write    = psel && penable && pwrite && pready;

    // ------------------------------------------------------------------
    // Statistics RAM: read issued on accept, data valid in LOOKUP
    // ------------------------------------------------------------------
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    mmfn_pkg::entry_t      mem_wdata;
    mmfn_pkg::entry_t      mem_rdata;
    mmfn_pkg::entry_t      upd_entry;
    logic signed [W-1:0]   cur_lo;
    logic signed [W-1:0]   cur_hi;
    logic [W:0]            span_full;

    mmfn_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (in_accept),
        .raddr (look_addr),
        .rdata (mem_rdata)
    );

    // An entry that has not seen a sample reads as zero
    always_comb
    begin
        cur_lo    = mem_rdata.seen ? mem_rdata.low  : '0;
        cur_hi    = mem_rdata.seen ? mem_rdata.high : '0;
        span_full = {cur_hi[W-1], cur_hi} - {cur_lo[W-1], cur_lo};

        upd_entry      = mem_rdata;
        upd_entry.seen = 1'b1;
        priority if (!mem_rdata.seen)
        begin
            upd_entry.low  = x_reg;
            upd_entry.high = x_reg;
        end
        else if (x_reg < mem_rdata.low)
        begin
            upd_entry.low = x_reg;
        end
        else if (x_reg > mem_rdata.high)
        begin
            upd_entry.high = x_reg;
        end
    end

    // ------------------------------------------------------------------
    // Normalise setup: |x - lo| << FRAC_W over span, sign kept aside
    // ------------------------------------------------------------------
    logic signed [W:0]     diff;
    logic [W:0]            abs_full;
    logic [W-1:0]          abs_diff;
    logic                  diff_neg;
    logic                  norm_ovf;
    logic                  span_zero;
    logic signed [PROD_W:0] prod_full;

    always_comb
    begin
        diff      = $signed({x_reg[W-1], x_reg}) - $signed({lo_reg[W-1], lo_reg});
        diff_neg  = diff[W];
        abs_full  = diff_neg ? -diff : diff;
        abs_diff  = abs_full[W-1:0];
        span_zero = span_reg == '0;
        // High dividend part not below the span: quotient needs more than W bits
        norm_ovf  = {{FRAC_W{1'b0}}, abs_diff[W-1:W-FRAC_W]} >= span_reg;
    end

    assign prod_full = x_reg * $signed({1'b0, span_reg});

    // ------------------------------------------------------------------
    // Divider
    // ------------------------------------------------------------------
    mmfn_pkg::div_req_t    div_req;
    mmfn_pkg::div_rsp_t    div_rsp;

    assign div_req.start    = (state_reg == mmfn_pkg::ST_SETUP) &&
                              (kind_reg == mmfn_pkg::KIND_NORM) && !span_zero && !norm_ovf;
    assign div_req.rem_init = {{FRAC_W{1'b0}}, abs_diff[W-1:W-FRAC_W]};
    assign div_req.dq_init  = {abs_diff[W-FRAC_W-1:0], {FRAC_W{1'b0}}};
    assign div_req.divisor  = span_reg;

    mmfn_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Apply the sign to the quotient and clip
    logic signed [W-1:0]   div_res;
    logic                  div_sat;

    always_comb
    begin
        if (!neg_reg)
        begin
            div_sat = div_rsp.quotient[W-1];
            div_res = div_sat ? mmfn_pkg::Q_MAX : $signed(div_rsp.quotient);
        end
        else
        begin
            div_sat = div_rsp.quotient > W'(mmfn_pkg::Q_MIN);
            div_res = div_sat ? mmfn_pkg::Q_MIN : $signed(-div_rsp.quotient);
        end
    end

    // ------------------------------------------------------------------
    // Denormalise: floor(product / 2^FRAC_W) + lo, clipped
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0] scale_sum;
    logic [SUM_W-W:0]        scale_hi;
    logic                    scale_pos_ovf;
    logic                    scale_neg_ovf;
    logic signed [W-1:0]     scale_res;

    always_comb
    begin
        scale_sum     = $signed({prod_reg[PROD_W-1], prod_reg[PROD_W-1:FRAC_W]})
                        + $signed({{(SUM_W-W){lo_reg[W-1]}}, lo_reg});
        scale_hi      = scale_sum[SUM_W-1:W-1];
        scale_pos_ovf = !scale_sum[SUM_W-1] && (|scale_hi);
        scale_neg_ovf = scale_sum[SUM_W-1] && !(&scale_hi);
        priority if (scale_pos_ovf)
        begin
            scale_res = mmfn_pkg::Q_MAX;
        end
        else if (scale_neg_ovf)
        begin
            scale_res = mmfn_pkg::Q_MIN;
        end
        else
        begin
            scale_res = scale_sum[W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mmfn_pkg::ST_CLEAR:
            begin
                if (clr_addr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = mmfn_pkg::ST_IDLE;
                end
            end
            mmfn_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    priority if (kind == mmfn_pkg::KIND_CLEAR)
                    begin
                        state_next = mmfn_pkg::ST_CLEAR;
                    end
                    else if (need_lookup)
                    begin
                        state_next = mmfn_pkg::ST_LOOKUP;
                    end
                    else if (pass_result)
                    begin
                        state_next = mmfn_pkg::ST_FINISH;
                    end
                    else
                    begin
                        state_next = mmfn_pkg::ST_IDLE;
                    end
                end
            end
            mmfn_pkg::ST_LOOKUP:
            begin
                state_next = (kind_reg == mmfn_pkg::KIND_COLLECT) ? mmfn_pkg::ST_IDLE
                                                                  : mmfn_pkg::ST_SETUP;
            end
            mmfn_pkg::ST_SETUP:
            begin
                if (kind_reg == mmfn_pkg::KIND_NORM)
                begin
                    state_next = (span_zero || norm_ovf) ? mmfn_pkg::ST_FINISH
                                                         : mmfn_pkg::ST_DIVIDE;
                end
                else
                begin
                    state_next = mmfn_pkg::ST_SCALE;
                end
            end
            mmfn_pkg::ST_DIVIDE:
            begin
                if (div_rsp.done)
                begin
                    state_next = mmfn_pkg::ST_FINISH;
                end
            end
            mmfn_pkg::ST_SCALE:
            begin
                state_next = mmfn_pkg::ST_FINISH;
            end
            mmfn_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = mmfn_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mmfn_pkg::ST_CLEAR;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // State outputs: input stall and RAM write port
    // ------------------------------------------------------------------
    always_comb
    begin
        // One request at a time; the write-back completes before the next read
        in_stall  = (state_reg != mmfn_pkg::ST_IDLE);
        mem_we    = 1'b0;
        mem_waddr = addr_reg;
        mem_wdata = upd_entry;
        unique case (state_reg)
            mmfn_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                mem_wdata = '0;
            end
            mmfn_pkg::ST_LOOKUP:
            begin
                mem_we = (kind_reg == mmfn_pkg::KIND_COLLECT);
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= mmfn_pkg::ST_CLEAR;
            clr_addr_reg    <= '0;
            stats_ready_reg <= 1'b0;
            denorm_en_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_write && paddr[2] == mmfn_pkg::REG_DENORM_EN)
            begin
                denorm_en_reg <= pwdata[0];
            end

            if (state_reg == mmfn_pkg::ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            else if (in_accept && kind == mmfn_pkg::KIND_CLEAR)
            begin
                clr_addr_reg <= '0;
            end

            // Any collect or clear invalidates the statistics; finish arms them
            if (in_accept)
            begin
                if (kind == mmfn_pkg::KIND_CLEAR || kind == mmfn_pkg::KIND_COLLECT)
                begin
                    stats_ready_reg <= 1'b0;
                end
                else if (kind == mmfn_pkg::KIND_FINISH)
                begin
                    stats_ready_reg <= 1'b1;
                end
            end

            // Output register parts the result from the rest of the pipe
            if (state_reg == mmfn_pkg::ST_FINISH && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            kind_reg <= kind;
            x_reg    <= sample_value;
            addr_reg <= look_addr;
            // Pass-through result: value unchanged, no clipping
            res_reg  <= sample_value;
            sat_reg  <= 1'b0;
        end

        unique case (state_reg)
            mmfn_pkg::ST_LOOKUP:
            begin
                lo_reg   <= cur_lo;
                span_reg <= span_full[W-1:0];
            end
            mmfn_pkg::ST_SETUP:
            begin
                neg_reg  <= diff_neg;
                prod_reg <= prod_full[PROD_W-1:0];
                if (span_zero)
                begin
                    res_reg <= '0;
                    sat_reg <= 1'b0;
                end
                else if (norm_ovf)
                begin
                    res_reg <= diff_neg ? mmfn_pkg::Q_MIN : mmfn_pkg::Q_MAX;
                    sat_reg <= 1'b1;
                end
            end
            mmfn_pkg::ST_DIVIDE:
            begin
                if (div_rsp.done)
                begin
                    res_reg <= div_res;
                    sat_reg <= div_sat;
                end
            end
            mmfn_pkg::ST_SCALE:
            begin
                res_reg <= scale_res;
                sat_reg <= scale_pos_ovf || scale_neg_ovf;
            end
            default:
            begin
            end
        endcase

        if (state_reg == mmfn_pkg::ST_FINISH && out_free)
        begin
            result_value_reg <= res_reg;
            saturated_reg    <= sat_reg;
        end
    end

    // ------------------------------------------------------------------
    // Ports
    // ------------------------------------------------------------------
    assign out_valid    = out_valid_reg;
    assign result_value = result_value_reg;
    assign saturated    = saturated_reg;
    assign pready       = 1'b1;
    assign prdata       = (paddr[2] == mmfn_pkg::REG_DENORM_EN)
                          ? {{(mmfn_pkg::CFG_DATA_W-1){1'b0}}, denorm_en_reg} : '0;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `MMFN_ASSERT_SAME(a_div_done_in_divide, div_rsp.done, state_reg == mmfn_pkg::ST_DIVIDE, "divider finished outside the divide state")
    `MMFN_ASSERT_SAME(a_store_ordered, mem_we && state_reg != mmfn_pkg::ST_CLEAR, mem_wdata.seen && (mem_wdata.low <= mem_wdata.high), "collect wrote an entry with min above max")
    `MMFN_ASSERT_NEXT(a_finish_delivers, state_reg == mmfn_pkg::ST_FINISH && out_free, out_valid_reg && state_reg == mmfn_pkg::ST_IDLE, "finished result not presented")

endmodule
